/* hdl/mrpt_pkg.sv */
// package for the miller-rabin prime test core
// holds widths, witness table, controller state type and datapath command/status structs; no dependencies
`timescale 1ns / 1ps

package mrpt_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CandWidth  = 32;
  localparam int unsigned NumWitness = 5;
  localparam int unsigned WitIdxW    = 3;

  function automatic logic [3:0] witness_base(input logic [WitIdxW-1:0] idx);
    logic [3:0] b;
    begin
      case (idx)
        3'd0:    b = 4'd2;
        3'd1:    b = 4'd3;
        3'd2:    b = 4'd5;
        3'd3:    b = 4'd7;
        default: b = 4'd11;
      endcase
      return b;
    end
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_WIT_START,
    ST_POW_BIT,
    ST_POW_MUL_RES,
    ST_POW_MUL_SQ,
    ST_WIT_EVAL,
    ST_SQ_CHECK,
    ST_SQ_MUL,
    ST_DONE
  } ctrl_state_e;

  // datapath commands
  typedef struct packed {
    logic load;       // capture candidate
    logic shift_d;    // strip one trailing zero of d
    logic wit_init;   // result = 1, base = witness mod n, e = d
    logic mul_start;  // start a modular multiply
    logic mul_sel;    // 0: result*base, 1: square (base if mul_dst, else result)
    logic mul_dst;    // 0: write result, 1: write base
    logic e_shift;    // drop the lowest exponent bit
    logic r_clr;      // clear squaring counter
    logic r_inc;      // bump squaring counter
    logic set_prime;
    logic clr_prime;
  } dp_cmd_t;

  // datapath status
  typedef struct packed {
    logic n_small;    // n < 2
    logic n_witness;  // n equals a witness
    logic d_even;
    logic e_zero;
    logic e_lsb;
    logic mul_busy;
    logic x_one;
    logic x_nm1;
    logic r_done;     // r == s
  } dp_sts_t;

endpackage

/* hdl/mrpt_if.sv */
// valid/ready channel interface for the prime test core
// depends on nothing
`timescale 1ns / 1ps

interface mrpt_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/miller_rabin_prime_test_core.sv */
// miller-rabin prime test core, witnesses 2, 3, 5, 7 and 11
// candidates 0, 1 and the witnesses are decided without a modular multiply;
// one candidate at a time; reset clears control and the output valid
`timescale 1ns / 1ps

module miller_rabin_prime_test_core #(
  parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrpt_if.sink   in_if,
  mrpt_if.source out_if
);
  mrpt_pkg::dp_cmd_t cmd;
  mrpt_pkg::dp_sts_t sts;
  logic [mrpt_pkg::WitIdxW-1:0] wit_idx;
  logic is_prime;

  mrpt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd), .wit_idx_o(wit_idx)
  );

  mrpt_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .candidate_i(in_if.data[mrpt_pkg::CandWidth-1:0]),
    .cmd_i(cmd), .wit_idx_i(wit_idx),
    .sts_o(sts), .is_prime_o(is_prime)
  );

  assign out_if.data = is_prime;
endmodule

/* hdl/mrpt_mulmod.sv */
// iterative shift-and-add modular multiplier, one bit per cycle
// depends on mrpt_pkg
`timescale 1ns / 1ps

module mrpt_mulmod #(
  parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] x_i,
  input  logic [VALUE_WIDTH-1:0] y_i,
  input  logic [VALUE_WIDTH-1:0] m_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] p_o
);
  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] acc_q, acc_d, y_q, y_d, x_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic [VALUE_WIDTH:0]   dbl, dbl_r, add, add_r;

  always_comb begin
    // acc = 2*acc mod m, then add x mod m when the top bit of y is set
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add   = dbl_r + {1'b0, x_q};
    add_r = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    acc_d  = acc_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      y_d    = y_i;
      cnt_d  = CntW'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = y_q[VALUE_WIDTH-1] ? add_r[VALUE_WIDTH-1:0] : dbl_r[VALUE_WIDTH-1:0];
      y_d   = {y_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    y_q   <= y_d;
    if (start_i) x_q <= x_i;
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;
endmodule

/* hdl/mrpt_datapath.sv */
// datapath: candidate, d, s, exponent, result, base, squaring counter and prime flag registers
// depends on mrpt_pkg and mrpt_mulmod
`timescale 1ns / 1ps

module mrpt_datapath #(
  parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mrpt_pkg::CandWidth-1:0]    candidate_i,
  input  mrpt_pkg::dp_cmd_t                 cmd_i,
  input  logic [mrpt_pkg::WitIdxW-1:0]      wit_idx_i,
  output mrpt_pkg::dp_sts_t                 sts_o,
  output logic                              is_prime_o
);
  localparam int unsigned SW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] n_q, d_q, e_q, res_q, base_q;
  logic [SW-1:0]          s_q, r_q;
  logic                   prime_q;
  logic [VALUE_WIDTH-1:0] mx, my, prod, wit, nm1;
  logic [VALUE_WIDTH-1:0] wit_r1, wit_red;
  logic                   mbusy;
  logic                   mbusy_q;
  logic                   wb_dst_q;

  assign nm1 = n_q - 1'b1;
  assign wit = VALUE_WIDTH'(mrpt_pkg::witness_base(wit_idx_i));
  assign mx  = (cmd_i.mul_sel && cmd_i.mul_dst) ? base_q : res_q;
  assign my  = cmd_i.mul_sel ? mx : base_q;

  // witness mod n: witness is at most 11 and n is at least 4 here
  assign wit_r1  = (wit >= n_q) ? wit - n_q : wit;
  assign wit_red = (wit_r1 >= n_q) ? wit_r1 - n_q : wit_r1;

  mrpt_mulmod #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mul_start),
    .x_i(mx), .y_i(my), .m_i(n_q),
    .busy_o(mbusy), .p_o(prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= VALUE_WIDTH'(candidate_i);
      d_q <= VALUE_WIDTH'(candidate_i) - 1'b1;
      s_q <= '0;
    end
    if (cmd_i.shift_d) begin
      d_q <= d_q >> 1;
      s_q <= s_q + 1'b1;
    end
    if (cmd_i.wit_init) begin
      res_q  <= VALUE_WIDTH'(1);
      base_q <= wit_red;
      e_q    <= d_q;
    end
    if (cmd_i.e_shift) e_q <= e_q >> 1;
    if (cmd_i.r_clr) r_q <= '0;
    if (cmd_i.r_inc) r_q <= r_q + 1'b1;
    // product write-back when mulmod busy falls, before the controller sees mul_busy low
    if (mbusy_q && !mbusy) begin
      if (wb_dst_q) base_q <= prod;
      else          res_q  <= prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q  <= 1'b0;
      wb_dst_q <= 1'b0;
      prime_q  <= 1'b0;
    end else begin
      mbusy_q <= mbusy;
      if (cmd_i.mul_start) wb_dst_q <= cmd_i.mul_dst;
      if (cmd_i.set_prime) prime_q <= 1'b1;
      if (cmd_i.clr_prime) prime_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.n_small   = (n_q < VALUE_WIDTH'(2));
    sts_o.n_witness = (n_q == VALUE_WIDTH'(2)) || (n_q == VALUE_WIDTH'(3)) ||
                      (n_q == VALUE_WIDTH'(5)) || (n_q == VALUE_WIDTH'(7)) ||
                      (n_q == VALUE_WIDTH'(11));
    sts_o.d_even    = ~d_q[0] && (d_q != '0);
    sts_o.e_zero    = (e_q == '0);
    sts_o.e_lsb     = e_q[0];
    sts_o.mul_busy  = mbusy | mbusy_q;
    sts_o.x_one     = (res_q == VALUE_WIDTH'(1));
    sts_o.x_nm1     = (res_q == nm1);
    sts_o.r_done    = (r_q == s_q);
  end

  assign is_prime_o = prime_q;
endmodule

/* hdl/mrpt_ctrl.sv */
// controller state machine for the prime test
// depends on mrpt_pkg
`timescale 1ns / 1ps

module mrpt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  mrpt_pkg::dp_sts_t             sts_i,
  output mrpt_pkg::dp_cmd_t             cmd_o,
  output logic [mrpt_pkg::WitIdxW-1:0]  wit_idx_o
);
  mrpt_pkg::ctrl_state_e state_q, state_d;
  logic [mrpt_pkg::WitIdxW-1:0] wit_q, wit_d;
  logic vld_q, vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrpt_pkg::ST_IDLE;
      wit_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wit_q   <= wit_d;
      vld_q   <= vld_d;
    end
  end

  always_comb begin
    state_d = state_q;
    wit_d   = wit_q;
    vld_d   = vld_q;
    cmd_o   = '0;
    if (vld_q && out_ready_i) vld_d = 1'b0;
    in_ready_o = (state_q == mrpt_pkg::ST_IDLE) && (!vld_q || out_ready_i);
    unique case (state_q)
      mrpt_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = mrpt_pkg::ST_CHECK;
        end
      end
      mrpt_pkg::ST_CHECK: begin
        if (sts_i.n_small) begin
          cmd_o.clr_prime = 1'b1;
          state_d = mrpt_pkg::ST_DONE;
        end else if (sts_i.n_witness) begin
          cmd_o.set_prime = 1'b1;
          state_d = mrpt_pkg::ST_DONE;
        end else begin
          state_d = mrpt_pkg::ST_SPLIT;
        end
        wit_d = '0;
      end
      mrpt_pkg::ST_SPLIT: begin
        if (sts_i.d_even) cmd_o.shift_d = 1'b1;
        else              state_d = mrpt_pkg::ST_WIT_START;
      end
      mrpt_pkg::ST_WIT_START: begin
        cmd_o.wit_init = 1'b1;
        state_d = mrpt_pkg::ST_POW_BIT;
      end
      mrpt_pkg::ST_POW_BIT: begin
        if (sts_i.e_zero) begin
          state_d = mrpt_pkg::ST_WIT_EVAL;
        end else if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          state_d = mrpt_pkg::ST_POW_MUL_RES;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel = 1'b1;
          cmd_o.mul_dst = 1'b1;
          cmd_o.e_shift = 1'b1;
          state_d = mrpt_pkg::ST_POW_MUL_SQ;
        end
      end
      mrpt_pkg::ST_POW_MUL_RES: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel = 1'b1;
          cmd_o.mul_dst = 1'b1;
          cmd_o.e_shift = 1'b1;
          state_d = mrpt_pkg::ST_POW_MUL_SQ;
        end
      end
      mrpt_pkg::ST_POW_MUL_SQ: begin
        if (!sts_i.mul_busy) state_d = mrpt_pkg::ST_POW_BIT;
      end
      mrpt_pkg::ST_WIT_EVAL: begin
        cmd_o.r_clr = 1'b1;
        if (sts_i.x_one) state_d = mrpt_pkg::ST_DONE;
        else             state_d = mrpt_pkg::ST_SQ_CHECK;
        if (sts_i.x_one) begin
          if (wit_q == mrpt_pkg::WitIdxW'(mrpt_pkg::NumWitness - 1)) begin
            cmd_o.set_prime = 1'b1;
          end else begin
            wit_d = wit_q + 1'b1;
            state_d = mrpt_pkg::ST_WIT_START;
          end
        end
      end
      mrpt_pkg::ST_SQ_CHECK: begin
        if (sts_i.r_done) begin
          cmd_o.clr_prime = 1'b1;
          state_d = mrpt_pkg::ST_DONE;
        end else if (sts_i.x_nm1) begin
          if (wit_q == mrpt_pkg::WitIdxW'(mrpt_pkg::NumWitness - 1)) begin
            cmd_o.set_prime = 1'b1;
            state_d = mrpt_pkg::ST_DONE;
          end else begin
            wit_d = wit_q + 1'b1;
            state_d = mrpt_pkg::ST_WIT_START;
          end
        end else begin
          // square the result in place
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel = 1'b1;
          cmd_o.r_inc = 1'b1;
          state_d = mrpt_pkg::ST_SQ_MUL;
        end
      end
      mrpt_pkg::ST_SQ_MUL: begin
        if (!sts_i.mul_busy) state_d = mrpt_pkg::ST_SQ_CHECK;
      end
      mrpt_pkg::ST_DONE: begin
        vld_d = 1'b1;
        state_d = mrpt_pkg::ST_IDLE;
      end
      default: state_d = mrpt_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = vld_q;
  assign wit_idx_o   = wit_q;
endmodule
